### rtl/core/kpp_pkg.sv
// shared constants, types and helper functions for the k-means++ seeding block
package kpp_pkg;

	// default sizes
	localparam int DEF_MAX_POINTS   = 1024;
	localparam int DEF_MAX_FEATURES = 16;
	localparam int DEF_MAX_CLUSTERS = 16;
	localparam int DEF_MAX_TRIALS   = 8;
	localparam int DEF_FEATURE_BITS = 16;

	// fixed formats
	localparam int DIST_W     = 40;
	localparam int WEIGHT_W   = 16;
	localparam int POT_W      = 64;
	localparam int RNG_W      = 32;
	localparam int PROD_W     = DIST_W + WEIGHT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// request codes
	localparam logic [1:0] REQ_FEATURE = 2'd0;
	localparam logic [1:0] REQ_WEIGHT  = 2'd1;
	localparam logic [1:0] REQ_START   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_TRIALS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED     = 3'd4;

	// phase of the run
	typedef enum logic [2:0] {
		MODE_FIRST  = 3'b001,
		MODE_TRIAL  = 3'b010,
		MODE_UPDATE = 3'b100
	} mode_t;

	// controller to datapath
	typedef struct packed {
		mode_t mode;
		logic  ld_cfg;
		logic  tot_acc;
		logic  rng_step;
		logic  draw_mul;
		logic  draw_sum;
		logic  uni_pick;
		logic  scan_mul;
		logic  scan_acc;
		logic  emit;
		logic  cpy_init;
		logic  cpy_rd;
		logic  cpy_wr;
		logic  pass_init;
		logic  pt_start;
		logic  ft_sq;
		logic  ft_acc;
		logic  pt_min;
		logic  pt_mul;
		logic  pt_add;
		logic  pass_end;
	} kpp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic i_last;
		logic f_last;
		logic t_last;
		logic c_last;
		logic hit;
		logic total_zero;
	} kpp_stat_t;

	// one xorshift step
	function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] x);
		logic [RNG_W-1:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

	// saturating 64-bit add
	function automatic logic [POT_W-1:0] sat_add64(input logic [POT_W-1:0] a,
			input logic [POT_W-1:0] b);
		logic [POT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[POT_W] ? '1 : s[POT_W-1:0];
	endfunction

endpackage

### rtl/core/kpp_ram.sv
// generic single write port, single registered read port ram
module kpp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic [AW-1:0]          raddr,
	output logic [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/core/kpp_ctrl.sv
// seeding controller state machine
module kpp_ctrl import kpp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  kpp_stat_t stat,
	output kpp_cmd_t  cmd,
	output logic      busy
);
	typedef enum logic [23:0] {
		S_IDLE      = 24'h000001,
		S_INIT      = 24'h000002,
		S_TOT_RD    = 24'h000004,
		S_TOT_ACC   = 24'h000008,
		S_DRAW_A    = 24'h000010,
		S_DRAW_B    = 24'h000020,
		S_DRAW_C    = 24'h000040,
		S_UNI_PICK  = 24'h000080,
		S_SCAN_RD   = 24'h000100,
		S_SCAN_MUL  = 24'h000200,
		S_SCAN_ACC  = 24'h000400,
		S_EMIT      = 24'h000800,
		S_CPY_INIT  = 24'h001000,
		S_CPY_RD    = 24'h002000,
		S_CPY_WR    = 24'h004000,
		S_PASS_INIT = 24'h008000,
		S_PT_START  = 24'h010000,
		S_FT_RD     = 24'h020000,
		S_FT_SQ     = 24'h040000,
		S_FT_ACC    = 24'h080000,
		S_PT_MIN    = 24'h100000,
		S_PT_MUL    = 24'h200000,
		S_PT_ADD    = 24'h400000,
		S_PASS_END  = 24'h800000
	} state_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;

	// state and phase registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_FIRST;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		cmd      = '0;
		cmd.mode = mode_q;
		state_d  = state_q;
		mode_d   = mode_q;
		case (state_q)
			S_IDLE: begin
				if (go) begin
					state_d = S_INIT;
					mode_d  = MODE_FIRST;
				end
			end
			S_INIT: begin
				cmd.ld_cfg = 1'b1;
				state_d    = S_TOT_RD;
			end
			S_TOT_RD: state_d = S_TOT_ACC;
			S_TOT_ACC: begin
				cmd.tot_acc = 1'b1;
				state_d     = stat.i_last ? S_DRAW_A : S_TOT_RD;
			end
			S_DRAW_A: begin
				cmd.rng_step = 1'b1;
				state_d      = S_DRAW_B;
			end
			S_DRAW_B: begin
				cmd.draw_mul = 1'b1;
				state_d      = S_DRAW_C;
			end
			S_DRAW_C: begin
				cmd.draw_sum = 1'b1;
				if (mode_q == MODE_FIRST && stat.total_zero) begin
					state_d = S_UNI_PICK;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_UNI_PICK: begin
				cmd.uni_pick = 1'b1;
				state_d      = S_EMIT;
			end
			S_SCAN_RD: state_d = S_SCAN_MUL;
			S_SCAN_MUL: begin
				cmd.scan_mul = 1'b1;
				state_d      = S_SCAN_ACC;
			end
			S_SCAN_ACC: begin
				cmd.scan_acc = 1'b1;
				if (stat.hit || stat.i_last) begin
					state_d = (mode_q == MODE_FIRST) ? S_EMIT : S_CPY_INIT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.c_last) begin
					state_d = S_IDLE;
				end else if (mode_q == MODE_FIRST) begin
					state_d = S_CPY_INIT;
				end else begin
					mode_d  = MODE_TRIAL;
					state_d = S_DRAW_A;
				end
			end
			S_CPY_INIT: begin
				cmd.cpy_init = 1'b1;
				state_d      = S_CPY_RD;
			end
			S_CPY_RD: begin
				cmd.cpy_rd = 1'b1;
				state_d    = S_CPY_WR;
			end
			S_CPY_WR: begin
				cmd.cpy_wr = 1'b1;
				state_d    = stat.f_last ? S_PASS_INIT : S_CPY_RD;
			end
			S_PASS_INIT: begin
				cmd.pass_init = 1'b1;
				state_d       = S_PT_START;
			end
			S_PT_START: begin
				cmd.pt_start = 1'b1;
				state_d      = S_FT_RD;
			end
			S_FT_RD: state_d = S_FT_SQ;
			S_FT_SQ: begin
				cmd.ft_sq = 1'b1;
				state_d   = S_FT_ACC;
			end
			S_FT_ACC: begin
				cmd.ft_acc = 1'b1;
				state_d    = stat.f_last ? S_PT_MIN : S_FT_RD;
			end
			S_PT_MIN: begin
				cmd.pt_min = 1'b1;
				state_d    = S_PT_MUL;
			end
			S_PT_MUL: begin
				cmd.pt_mul = 1'b1;
				state_d    = S_PT_ADD;
			end
			S_PT_ADD: begin
				cmd.pt_add = 1'b1;
				state_d    = stat.i_last ? S_PASS_END : S_PT_START;
			end
			S_PASS_END: begin
				cmd.pass_end = 1'b1;
				case (mode_q)
					MODE_FIRST: begin
						mode_d  = MODE_TRIAL;
						state_d = S_DRAW_A;
					end
					MODE_TRIAL: begin
						if (stat.t_last) begin
							mode_d  = MODE_UPDATE;
							state_d = S_CPY_INIT;
						end else begin
							state_d = S_DRAW_A;
						end
					end
					MODE_UPDATE: state_d = S_EMIT;
					default: state_d = S_IDLE;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### rtl/core/kpp_dpath.sv
// seeding datapath: stores, counters, distance unit, draw unit, result register
module kpp_dpath import kpp_pkg::*; #(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int MAX_FEATURES = DEF_MAX_FEATURES,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_TRIALS   = DEF_MAX_TRIALS,
	parameter int FEATURE_BITS = DEF_FEATURE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic [1:0]            req_type,
	input  logic [9:0]            point_index,
	input  logic [3:0]            feature_index,
	input  logic signed [15:0]    feature_value,
	input  logic [15:0]           weight_value,
	input  kpp_cmd_t              cmd,
	output kpp_stat_t             stat,
	output logic                  center_valid,
	output logic [3:0]            center_rank,
	output logic [9:0]            center_point,
	output logic                  last_center
);
	localparam int PW    = $clog2(MAX_POINTS);
	localparam int NW    = $clog2(MAX_POINTS + 1);
	localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int TW    = (MAX_TRIALS > 1) ? $clog2(MAX_TRIALS) : 1;
	localparam int FDEP  = MAX_POINTS * MAX_FEATURES;
	localparam int FAW   = $clog2(FDEP);
	localparam int SQ_W  = 2 * FEATURE_BITS + 2;
	localparam int ACC_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

	// configuration registers
	logic [10:0]           num_points_q;
	logic [4:0]            num_features_q;
	logic [4:0]            num_clusters_q;
	logic [3:0]            local_trials_q;
	logic [RNG_W-1:0]      rng_seed_q;

	// run registers
	logic [NW-1:0]         n_q;
	logic [PW-1:0]         nm1_q;
	logic [FW-1:0]         nfm1_q;
	logic [CW-1:0]         km1_q;
	logic [TW-1:0]         tm1_q;
	logic [PW-1:0]         i_q;
	logic [FW-1:0]         f_q;
	logic [CW-1:0]         c_q;
	logic [TW-1:0]         t_q;
	logic [POT_W-1:0]      total_q;
	logic [RNG_W-1:0]      rng_q;
	logic [POT_W-1:0]      hi_q;
	logic [POT_W-1:0]      lo_q;
	logic [POT_W-1:0]      r_q;
	logic [POT_W-1:0]      cum_q;
	logic [PW-1:0]         cand_q;
	logic [PW-1:0]         best_id_q;
	logic [POT_W-1:0]      best_q;
	logic [POT_W-1:0]      pot_q;
	logic [POT_W-1:0]      potacc_q;
	logic [SQ_W-1:0]       sq_q;
	logic [DIST_W-1:0]     acc_q;
	logic [DIST_W-1:0]     m_q;
	logic [PROD_W-1:0]     prod_q;

	// ram ports
	logic                     feat_we;
	logic [FAW-1:0]           feat_waddr;
	logic [FAW-1:0]           feat_raddr;
	logic [FEATURE_BITS-1:0]  feat_wdata;
	logic [FEATURE_BITS-1:0]  feat_rdata;
	logic [FEATURE_BITS-1:0]  cbuf_rdata;
	logic                     wt_we;
	logic [WEIGHT_W-1:0]      wt_rdata;
	logic                     nd_we;
	logic [DIST_W-1:0]        nd_rdata;

	// run setup values
	logic [31:0] n_c, nf_c, k_c, tr_c, lg_c;

	// combinational datapath values
	logic [PW-1:0]              src_id;
	logic signed [FEATURE_BITS:0] diff;
	logic signed [SQ_W-1:0]     diff_x;
	logic [SQ_W-1:0]            sq_d;
	logic [ACC_W-1:0]           acc_sum;
	logic [DIST_W-1:0]          acc_d;
	logic [DIST_W-1:0]          min_d;
	logic [DIST_W-1:0]          mul_a;
	logic [POT_W-1:0]           opnd;
	logic [POT_W-1:0]           cum_next;
	logic                       is_first;

	assign is_first = (cmd.mode == MODE_FIRST);

	// load address decode
	assign feat_we    = accept && (req_type == REQ_FEATURE)
	                    && (32'(point_index) < MAX_POINTS)
	                    && (32'(feature_index) < MAX_FEATURES);
	assign feat_waddr = FAW'(32'(point_index) * MAX_FEATURES + 32'(feature_index));
	assign feat_wdata = FEATURE_BITS'(feature_value);
	assign wt_we      = accept && (req_type == REQ_WEIGHT) && (32'(point_index) < MAX_POINTS);

	// feature read address: chosen center during a copy, walked point otherwise
	assign src_id     = (cmd.mode == MODE_UPDATE) ? best_id_q : cand_q;
	assign feat_raddr = FAW'(cmd.cpy_rd ? src_id : i_q) * FAW'(MAX_FEATURES) + FAW'(f_q);

	kpp_ram #(.WIDTH(FEATURE_BITS), .DEPTH(FDEP)) u_feat_ram (
		.clk(clk), .we(feat_we), .waddr(feat_waddr), .wdata(feat_wdata),
		.raddr(feat_raddr), .rdata(feat_rdata)
	);

	kpp_ram #(.WIDTH(FEATURE_BITS), .DEPTH(MAX_FEATURES)) u_cbuf_ram (
		.clk(clk), .we(cmd.cpy_wr), .waddr(f_q), .wdata(feat_rdata),
		.raddr(f_q), .rdata(cbuf_rdata)
	);

	kpp_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_POINTS)) u_wt_ram (
		.clk(clk), .we(wt_we), .waddr(PW'(point_index)), .wdata(weight_value),
		.raddr(i_q), .rdata(wt_rdata)
	);

	kpp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_nd_ram (
		.clk(clk), .we(nd_we), .waddr(i_q), .wdata(min_d),
		.raddr(i_q), .rdata(nd_rdata)
	);

	// clamp registers into the run limits
	always_comb begin
		if (num_points_q == '0) n_c = 32'd1;
		else if (32'(num_points_q) > MAX_POINTS) n_c = MAX_POINTS;
		else n_c = 32'(num_points_q);

		if (num_features_q == '0) nf_c = 32'd1;
		else if (32'(num_features_q) > MAX_FEATURES) nf_c = MAX_FEATURES;
		else nf_c = 32'(num_features_q);

		if (num_clusters_q == '0) k_c = 32'd1;
		else if (32'(num_clusters_q) > MAX_CLUSTERS) k_c = MAX_CLUSTERS;
		else k_c = 32'(num_clusters_q);
		if (k_c > n_c) k_c = n_c;

		// 2 + floor(ln k)
		if (k_c >= 32'd55) lg_c = 32'd4;
		else if (k_c >= 32'd21) lg_c = 32'd3;
		else if (k_c >= 32'd8) lg_c = 32'd2;
		else if (k_c >= 32'd3) lg_c = 32'd1;
		else lg_c = 32'd0;

		tr_c = (local_trials_q == '0) ? (32'd2 + lg_c) : 32'(local_trials_q);
		if (tr_c > MAX_TRIALS) tr_c = MAX_TRIALS;
	end

	// squared feature difference, saturating distance accumulate
	assign diff    = signed'({feat_rdata[FEATURE_BITS-1], feat_rdata})
	               - signed'({cbuf_rdata[FEATURE_BITS-1], cbuf_rdata});
	assign diff_x  = SQ_W'(diff);
	assign sq_d    = unsigned'(diff_x * diff_x);
	assign acc_sum = ACC_W'(acc_q) + ACC_W'(sq_q);
	assign acc_d   = (acc_sum > ACC_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(acc_sum);

	// nearest distance for this point
	assign min_d = (is_first || acc_q < nd_rdata) ? acc_q : nd_rdata;
	assign nd_we = cmd.pt_min && (cmd.mode != MODE_TRIAL);

	// shared weight multiplier operand
	assign mul_a = cmd.scan_mul ? (is_first ? DIST_W'(1) : nd_rdata) : m_q;

	// draw operand and scan compare
	assign opnd     = is_first ? ((total_q == '0) ? POT_W'(n_q) : total_q) : pot_q;
	assign cum_next = sat_add64(cum_q, POT_W'(prod_q));

	assign stat.i_last     = (i_q == nm1_q);
	assign stat.f_last     = (f_q == nfm1_q);
	assign stat.t_last     = (t_q == tm1_q);
	assign stat.c_last     = (c_q == km1_q);
	assign stat.hit        = is_first ? (cum_next > r_q) : (cum_next >= r_q);
	assign stat.total_zero = (total_q == '0);

	// configuration and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q   <= 11'd1024;
			num_features_q <= 5'd16;
			num_clusters_q <= 5'd8;
			local_trials_q <= 4'd0;
			rng_seed_q     <= 32'd1;
			center_valid   <= 1'b0;
		end else begin
			center_valid <= cmd.emit;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_NUM_POINTS:   num_points_q   <= cfg_data[10:0];
					CFG_NUM_FEATURES: num_features_q <= cfg_data[4:0];
					CFG_NUM_CLUSTERS: num_clusters_q <= cfg_data[4:0];
					CFG_LOCAL_TRIALS: local_trials_q <= cfg_data[3:0];
					CFG_RNG_SEED:     rng_seed_q     <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// run datapath registers
	always_ff @(posedge clk) begin
		// run setup
		if (cmd.ld_cfg) begin
			n_q     <= NW'(n_c);
			nm1_q   <= PW'(n_c - 32'd1);
			nfm1_q  <= FW'(nf_c - 32'd1);
			km1_q   <= CW'(k_c - 32'd1);
			tm1_q   <= TW'(tr_c - 32'd1);
			rng_q   <= (rng_seed_q == '0) ? RNG_W'(1) : rng_seed_q;
			total_q <= '0;
			i_q     <= '0;
			c_q     <= '0;
			t_q     <= '0;
		end

		// weight total
		if (cmd.tot_acc) begin
			total_q <= total_q + POT_W'(wt_rdata);
			i_q     <= i_q + PW'(1);
		end

		// draw r = (x * operand) >> 32
		if (cmd.rng_step) rng_q <= xorshift32(rng_q);
		if (cmd.draw_mul) begin
			hi_q <= POT_W'(opnd[63:32]) * POT_W'(rng_q);
			lo_q <= POT_W'(opnd[31:0]) * POT_W'(rng_q);
		end
		if (cmd.draw_sum) begin
			r_q    <= hi_q + POT_W'(lo_q[63:32]);
			cum_q  <= '0;
			i_q    <= '0;
			cand_q <= nm1_q;
		end
		if (cmd.uni_pick) cand_q <= (r_q >= POT_W'(n_q)) ? nm1_q : PW'(r_q);

		// weighted product for scan and pass
		if (cmd.scan_mul || cmd.pt_mul) prod_q <= PROD_W'(mul_a) * PROD_W'(wt_rdata);

		// running sum scan
		if (cmd.scan_acc) begin
			cum_q <= cum_next;
			if (stat.hit) cand_q <= i_q;
			i_q <= i_q + PW'(1);
		end

		// center feature copy
		if (cmd.cpy_init) f_q <= '0;
		if (cmd.cpy_wr) f_q <= f_q + FW'(1);

		// distance pass
		if (cmd.pass_init) begin
			i_q      <= '0;
			potacc_q <= '0;
		end
		if (cmd.pt_start) begin
			f_q   <= '0;
			acc_q <= '0;
		end
		if (cmd.ft_sq) sq_q <= sq_d;
		if (cmd.ft_acc) begin
			acc_q <= acc_d;
			f_q   <= f_q + FW'(1);
		end
		if (cmd.pt_min) m_q <= min_d;
		if (cmd.pt_add) begin
			potacc_q <= sat_add64(potacc_q, POT_W'(prod_q));
			i_q      <= i_q + PW'(1);
		end

		// end of pass bookkeeping
		if (cmd.pass_end) begin
			case (cmd.mode)
				MODE_FIRST: pot_q <= potacc_q;
				MODE_TRIAL: begin
					if (t_q == '0 || potacc_q < best_q) begin
						best_q    <= potacc_q;
						best_id_q <= cand_q;
					end
					t_q <= t_q + TW'(1);
				end
				MODE_UPDATE: pot_q <= best_q;
				default: ;
			endcase
		end

		// result
		if (cmd.emit) begin
			center_rank  <= 4'(c_q);
			center_point <= 10'(src_id);
			last_center  <= stat.c_last;
			c_q          <= c_q + CW'(1);
			t_q          <= '0;
		end
	end
endmodule

### rtl/core/kmeans_plus_plus_seeding.sv
// top level of the greedy k-means++ seeding block
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------------
// request  | start / busy         | req_type, point_index, feature_index,
//          |                      | feature_value, weight_value
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
// result   | center_valid strobe  | center_rank, center_point, last_center
//
// load items are accepted while busy is low; busy stays low through loads.
// a start item runs a weight total, then per center a draw with a running-sum scan,
// and distance passes over the points, (k-1)*(trials+1) + 1 passes when k > 1;
// the single feature ram read port feeds the distance accumulator one feature at a time.
// reset returns control and the configuration registers to defaults; stores are written by loads.
// results are one-cycle strobes that the receiver cannot stall.
module kmeans_plus_plus_seeding import kpp_pkg::*; #(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int MAX_FEATURES = DEF_MAX_FEATURES,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_TRIALS   = DEF_MAX_TRIALS,
	parameter int FEATURE_BITS = DEF_FEATURE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            req_type,
	input  logic [9:0]            point_index,
	input  logic [3:0]            feature_index,
	input  logic signed [15:0]    feature_value,
	input  logic [15:0]           weight_value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  center_valid,
	output logic [3:0]            center_rank,
	output logic [9:0]            center_point,
	output logic                  last_center
);
	kpp_cmd_t  cmd;
	kpp_stat_t stat;
	logic      accept;
	logic      go;

	// item handshake
	assign accept    = start && !busy;
	assign go        = accept && (req_type == REQ_START);
	assign cfg_ready = 1'b1;

	kpp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .stat(stat), .cmd(cmd), .busy(busy)
	);

	kpp_dpath #(
		.MAX_POINTS(MAX_POINTS), .MAX_FEATURES(MAX_FEATURES),
		.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_TRIALS(MAX_TRIALS),
		.FEATURE_BITS(FEATURE_BITS)
	) u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.accept(accept), .req_type(req_type), .point_index(point_index),
		.feature_index(feature_index), .feature_value(feature_value),
		.weight_value(weight_value), .cmd(cmd), .stat(stat),
		.center_valid(center_valid), .center_rank(center_rank),
		.center_point(center_point), .last_center(last_center)
	);

`ifndef NO_ASSERTIONS
	// the final center ends the run
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		center_valid && last_center |-> !busy)
		else $error("last center seen while still busy");

	// earlier centers come while the run goes on
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		center_valid && !last_center |-> busy)
		else $error("non-final center seen while idle");

	// a run only begins from a start item
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && req_type == REQ_START))
		else $error("busy rose without a start item");
`endif
endmodule
